FILE: rtl/ajp13_body_chunk_deframer_core_assert.svh
// assertion macros used by the deframer parser
`ifndef AJP13_BODY_CHUNK_DEFRAMER_CORE_ASSERT_SVH
`define AJP13_BODY_CHUNK_DEFRAMER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define AJPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AJPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ajpd_pkg.sv
// types and constants for the ajp13 body chunk deframer
package ajpd_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC0  = 3'd0,
    PH_MAGIC1  = 3'd1,
    PH_LENHI   = 3'd2,
    PH_LENLO   = 3'd3,
    PH_TYPE    = 3'd4,
    PH_CHUNKHI = 3'd5,
    PH_CHUNKLO = 3'd6,
    PH_BODY    = 3'd7
  } phase_t;

  localparam logic [1:0] EV_DATA  = 2'd0;
  localparam logic [1:0] EV_END   = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  localparam logic [7:0] MAGIC_A0 = 8'h41;
  localparam logic [7:0] MAGIC_A1 = 8'h42;
  localparam logic [7:0] MAGIC_B0 = 8'h12;
  localparam logic [7:0] MAGIC_B1 = 8'h34;

  localparam logic [7:0] MSG_SEND_BODY_CHUNK = 8'd3;
  localparam logic [7:0] MSG_END_RESPONSE    = 8'd5;

  localparam logic [15:0] MAX_PACKET_LEN_RESET = 16'd8192;

  typedef struct packed {
    logic       present;
    logic [1:0] event_res;
    logic [7:0] payload;
    logic       chunk_last;
  } res_t;

endpackage

FILE: rtl/ajpd_in_stage.sv
// input register stage for incoming bytes
module ajpd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  // slot frees when the held byte moves on this cycle
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
    end
  end

endmodule

FILE: rtl/ajpd_parser.sv
// packet header and body chunk parser state machine
module ajpd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [15:0]     cfg_wr_data,
  input  logic            step,
  input  logic [7:0]      b,
  output ajpd_pkg::res_t  res
);

  `include "ajp13_body_chunk_deframer_core_assert.svh"

  ajpd_pkg::phase_t phase, phase_next;
  logic [15:0] max_packet_len;
  logic [7:0]  first_magic, first_magic_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] body_remaining, body_remaining_next;
  logic [15:0] chunk_remaining, chunk_remaining_next;
  logic        error_seen, error_seen_next;

  logic [15:0] body_dec;
  logic [15:0] chunk_dec;
  logic [15:0] len_word;
  logic [15:0] chunk_word;
  logic        magic_ok;
  logic        len_bad;
  logic        short_chunk;

  assign body_dec    = body_remaining - 16'd1;
  assign chunk_dec   = chunk_remaining - 16'd1;
  assign len_word    = {length_high, b};
  assign chunk_word  = {chunk_remaining[15:8], b};
  assign magic_ok    = (first_magic == ajpd_pkg::MAGIC_A0 && b == ajpd_pkg::MAGIC_A1) ||
                       (first_magic == ajpd_pkg::MAGIC_B0 && b == ajpd_pkg::MAGIC_B1);
  assign len_bad     = (len_word == 16'd0) || (len_word > max_packet_len);
  assign short_chunk = body_dec < 16'd2;

  // next phase
  always_comb begin
    phase_next = phase;
    if (!error_seen) begin
      unique case (phase)
        ajpd_pkg::PH_MAGIC0:  phase_next = ajpd_pkg::PH_MAGIC1;
        ajpd_pkg::PH_MAGIC1:  phase_next = ajpd_pkg::PH_LENHI;
        ajpd_pkg::PH_LENHI:   phase_next = ajpd_pkg::PH_LENLO;
        ajpd_pkg::PH_LENLO:   phase_next = ajpd_pkg::PH_TYPE;
        ajpd_pkg::PH_TYPE: begin
          if (b == ajpd_pkg::MSG_SEND_BODY_CHUNK) begin
            phase_next = ajpd_pkg::PH_CHUNKHI;
          end else begin
            phase_next = (body_dec == 16'd0) ? ajpd_pkg::PH_MAGIC0 : ajpd_pkg::PH_BODY;
          end
        end
        ajpd_pkg::PH_CHUNKHI: phase_next = ajpd_pkg::PH_CHUNKLO;
        ajpd_pkg::PH_CHUNKLO: begin
          phase_next = (body_dec == 16'd0) ? ajpd_pkg::PH_MAGIC0 : ajpd_pkg::PH_BODY;
        end
        ajpd_pkg::PH_BODY: begin
          phase_next = (body_remaining <= 16'd1) ? ajpd_pkg::PH_MAGIC0 : ajpd_pkg::PH_BODY;
        end
        default:              phase_next = ajpd_pkg::PH_MAGIC0;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    first_magic_next     = first_magic;
    length_high_next     = length_high;
    body_remaining_next  = body_remaining;
    chunk_remaining_next = chunk_remaining;
    error_seen_next      = error_seen;
    res                  = '0;
    if (step && !error_seen) begin
      unique case (phase)
        ajpd_pkg::PH_MAGIC0: first_magic_next = b;
        ajpd_pkg::PH_MAGIC1: begin
          if (!magic_ok) begin
            error_seen_next = 1'b1;
            res.present     = 1'b1;
            res.event_res   = ajpd_pkg::EV_ERROR;
          end
        end
        ajpd_pkg::PH_LENHI: length_high_next = b;
        ajpd_pkg::PH_LENLO: begin
          if (len_bad) begin
            error_seen_next = 1'b1;
            res.present     = 1'b1;
            res.event_res   = ajpd_pkg::EV_ERROR;
          end else begin
            body_remaining_next = len_word;
          end
        end
        ajpd_pkg::PH_TYPE: begin
          body_remaining_next  = body_dec;
          chunk_remaining_next = 16'd0;
          if (b == ajpd_pkg::MSG_SEND_BODY_CHUNK) begin
            // need both chunk length bytes inside the body
            if (short_chunk) begin
              error_seen_next = 1'b1;
              res.present     = 1'b1;
              res.event_res   = ajpd_pkg::EV_ERROR;
            end
          end else if (b == ajpd_pkg::MSG_END_RESPONSE) begin
            res.present   = 1'b1;
            res.event_res = ajpd_pkg::EV_END;
          end
        end
        ajpd_pkg::PH_CHUNKHI: begin
          chunk_remaining_next = {b, 8'd0};
          body_remaining_next  = body_dec;
        end
        ajpd_pkg::PH_CHUNKLO: begin
          body_remaining_next  = body_dec;
          // clip chunk to what is left of the packet
          chunk_remaining_next = (chunk_word > body_dec) ? body_dec : chunk_word;
        end
        ajpd_pkg::PH_BODY: begin
          if (body_remaining != 16'd0) begin
            body_remaining_next = body_dec;
          end
          if (chunk_remaining != 16'd0) begin
            chunk_remaining_next = chunk_dec;
            res.present          = 1'b1;
            res.event_res        = ajpd_pkg::EV_DATA;
            res.payload          = b;
            res.chunk_last       = (chunk_dec == 16'd0);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ajpd_pkg::PH_MAGIC0;
      error_seen      <= 1'b0;
      max_packet_len  <= ajpd_pkg::MAX_PACKET_LEN_RESET;
      first_magic     <= 8'd0;
      length_high     <= 8'd0;
      body_remaining  <= 16'd0;
      chunk_remaining <= 16'd0;
    end else begin
      if (cfg_wr_en) begin
        max_packet_len <= cfg_wr_data;
      end
      if (step) begin
        phase           <= phase_next;
        error_seen      <= error_seen_next;
        first_magic     <= first_magic_next;
        length_high     <= length_high_next;
        body_remaining  <= body_remaining_next;
        chunk_remaining <= chunk_remaining_next;
      end
    end
  end

  `AJPD_ASSERT_NEXT(a_error_sticky, error_seen, error_seen, "error flag cleared without reset")
  `AJPD_ASSERT_NOW(a_silent_after_error, error_seen, !res.present, "result after format error")
  `AJPD_ASSERT_NOW(a_event_fields_clean, res.present && res.event_res != ajpd_pkg::EV_DATA,
    res.payload == 8'd0 && !res.chunk_last, "non-data event carries payload or last")
  `AJPD_ASSERT_NOW(a_no_data_past_chunk,
    step && phase == ajpd_pkg::PH_BODY && chunk_remaining == 16'd0,
    !res.present, "data emitted after chunk exhausted")

endmodule

FILE: rtl/ajpd_out_reg.sv
// result register holding one item for the output channel
module ajpd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  ajpd_pkg::res_t res,
  input  logic           advance,
  output logic           out_valid,
  output logic [1:0]     event_res,
  output logic [7:0]     payload,
  output logic           chunk_last
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.present;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res  <= res.event_res;
      payload    <= res.payload;
      chunk_last <= res.chunk_last;
    end
  end

endmodule

FILE: rtl/ajp13_body_chunk_deframer_core.sv
// top level of the ajp13 body chunk deframer
// an accepted byte sits in the input register and is parsed as it moves into the result register
// throughput: one byte per cycle while the output is not stalled
// a stalled output holds both stages, and the input takes a byte whenever its slot frees
// reset (rst, synchronous): parser back to first magic byte, error flag cleared,
// max_packet_len back to 8192, both stages empty
module ajp13_body_chunk_deframer_core (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_packet_len
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // input byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_res,
  output logic [7:0]  payload,
  output logic        chunk_last
);

  logic           advance;
  logic           s1_valid;
  logic [7:0]     s1_byte;
  logic           step;
  ajpd_pkg::res_t res;

  // whole pipe moves when the result register is empty or being drained
  assign advance = !out_valid || out_ready;
  // held byte is parsed in the cycle it moves into the result register
  assign step    = s1_valid && advance;

  ajpd_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte)
  );

  // header checks, chunk length tracking and event generation
  ajpd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .b           (s1_byte),
    .res         (res)
  );

  // bytes that cause no result leave an empty slot behind
  ajpd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .event_res  (event_res),
    .payload    (payload),
    .chunk_last (chunk_last)
  );

endmodule

FILE: verif/tb_ajp13_body_chunk_deframer_core.sv
// testbench for ajp13_body_chunk_deframer_core: byte stream drivers, result scoreboard, run control
module tb_ajp13_body_chunk_deframer_core;

  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] data;
    logic       last;
  } deframe_res_t;

  // tracks the parser state byte by byte and holds the result items still owed
  class deframe_scoreboard;
    ajpd_pkg::phase_t ph;
    logic [7:0]   first_magic;
    logic [7:0]   length_high;
    logic [7:0]   msg_type;
    logic [15:0]  body_left;
    logic [15:0]  chunk_left;
    logic [15:0]  max_len;
    bit           errored;
    deframe_res_t owed_q[$];
    int           n_bytes;
    int           n_data;
    int           n_end;
    int           n_err;
    int           n_fail;

    function new();
      ph          = ajpd_pkg::PH_MAGIC0;
      first_magic = '0;
      length_high = '0;
      msg_type    = '0;
      body_left   = '0;
      chunk_left  = '0;
      max_len     = ajpd_pkg::MAX_PACKET_LEN_RESET;
      errored     = 1'b0;
      n_bytes     = 0;
      n_data      = 0;
      n_end       = 0;
      n_err       = 0;
      n_fail      = 0;
    endfunction

    function void set_max(logic [15:0] v);
      max_len = v;
    endfunction

    function void queue_result(logic [1:0] ev, logic [7:0] data, logic last);
      deframe_res_t r;
      r.ev   = ev;
      r.data = data;
      r.last = last;
      owed_q.push_back(r);
    endfunction

    // a format error is sticky: nothing after it produces a result
    function void raise_error();
      errored = 1'b1;
      queue_result(ajpd_pkg::EV_ERROR, 8'h00, 1'b0);
    endfunction

    function void flag(string msg);
      n_fail++;
      $display("%0t: %s", $time, msg);
    endfunction

    // called for every byte accepted on the input channel
    function void note_byte(logic [7:0] b);
      logic [15:0] len;
      n_bytes++;
      if (errored) return;
      case (ph)
        ajpd_pkg::PH_MAGIC0: begin
          first_magic = b;
          ph = ajpd_pkg::PH_MAGIC1;
        end
        ajpd_pkg::PH_MAGIC1: begin
          if ((first_magic == ajpd_pkg::MAGIC_A0 && b == ajpd_pkg::MAGIC_A1) ||
              (first_magic == ajpd_pkg::MAGIC_B0 && b == ajpd_pkg::MAGIC_B1))
            ph = ajpd_pkg::PH_LENHI;
          else raise_error();
        end
        ajpd_pkg::PH_LENHI: begin
          length_high = b;
          ph = ajpd_pkg::PH_LENLO;
        end
        ajpd_pkg::PH_LENLO: begin
          len = {length_high, b};
          if (len == 16'd0 || len > max_len) begin
            raise_error();
          end else begin
            body_left = len;
            ph = ajpd_pkg::PH_TYPE;
          end
        end
        ajpd_pkg::PH_TYPE: begin
          msg_type   = b;
          body_left  = body_left - 16'd1;
          chunk_left = '0;
          if (b == ajpd_pkg::MSG_SEND_BODY_CHUNK) begin
            // the chunk length needs two more body bytes
            if (body_left < 16'd2) raise_error();
            else ph = ajpd_pkg::PH_CHUNKHI;
          end else begin
            ph = (body_left == 16'd0) ? ajpd_pkg::PH_MAGIC0 : ajpd_pkg::PH_BODY;
            if (b == ajpd_pkg::MSG_END_RESPONSE) queue_result(ajpd_pkg::EV_END, 8'h00, 1'b0);
          end
        end
        ajpd_pkg::PH_CHUNKHI: begin
          chunk_left = {b, 8'h00};
          body_left  = body_left - 16'd1;
          ph = ajpd_pkg::PH_CHUNKLO;
        end
        ajpd_pkg::PH_CHUNKLO: begin
          chunk_left = chunk_left | {8'h00, b};
          body_left  = body_left - 16'd1;
          // a chunk never runs past the end of its packet
          if (chunk_left > body_left) chunk_left = body_left;
          ph = (body_left == 16'd0) ? ajpd_pkg::PH_MAGIC0 : ajpd_pkg::PH_BODY;
        end
        default: begin
          if (body_left != 16'd0) body_left = body_left - 16'd1;
          ph = (body_left == 16'd0) ? ajpd_pkg::PH_MAGIC0 : ajpd_pkg::PH_BODY;
          // bytes past the chunk payload are dropped
          if (chunk_left != 16'd0) begin
            chunk_left = chunk_left - 16'd1;
            queue_result(ajpd_pkg::EV_DATA, b, chunk_left == 16'd0);
          end
        end
      endcase
    endfunction

    // called for every result item accepted on the output channel
    function void check_result(logic [1:0] ev, logic [7:0] data, logic last);
      deframe_res_t want;
      if (owed_q.size() == 0) begin
        flag($sformatf("result item with none owed: event_res %0d payload 0x%02h chunk_last %0d",
                       ev, data, last));
        return;
      end
      want = owed_q.pop_front();
      case (want.ev)
        ajpd_pkg::EV_DATA: n_data++;
        ajpd_pkg::EV_END:  n_end++;
        default:           n_err++;
      endcase
      if (ev !== want.ev)
        flag($sformatf("event_res mismatch: expected %0d actual %0d", want.ev, ev));
      if (data !== want.data)
        flag($sformatf("payload mismatch: expected 0x%02h actual 0x%02h", want.data, data));
      if (last !== want.last)
        flag($sformatf("chunk_last mismatch: expected %0d actual %0d", want.last, last));
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;
  logic        in_valid    = 1'b0;
  logic [7:0]  data_byte   = 8'h00;
  logic        out_ready   = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  event_res;
  logic [7:0]  payload;
  logic        chunk_last;

  deframe_scoreboard sb;
  logic [7:0]        tx_q[$];
  int                burst_left = 0;
  int                n_writes   = 0;
  // receiver pattern and long hold-off bookkeeping
  int                rx_mode    = 0;
  int                rx_left    = 0;
  int                hold_left  = 0;
  int                hold_asked = 0;
  int                hold_done  = 0;

  ajp13_body_chunk_deframer_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .payload     (payload),
    .chunk_last  (chunk_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // both channels are sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(data_byte);
      if (out_valid && out_ready) sb.check_result(event_res, payload, chunk_last);
    end
  end

  // receiver: random stall pattern, plus a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done = hold_asked;
      hold_left = 299;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = (rx_mode == 3) ? $urandom_range(1, 6) : $urandom_range(1, 60);
      end
      rx_left--;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= 1'b0;
      endcase
    end
  end

  // sender: bursts of random length separated by random gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic flush_tx();
    while (tx_q.size() > 0) send_byte(tx_q.pop_front());
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait for every owed result, then let the pipeline empty of silent bytes
  task automatic wait_idle();
    int budget;
    budget = 20000;
    while (sb.owed_q.size() != 0 && budget > 0) begin
      @(posedge clk);
      budget--;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_max(v);
    n_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void add_magic();
    if ($urandom_range(0, 1) == 1) begin
      tx_q.push_back(ajpd_pkg::MAGIC_A0);
      tx_q.push_back(ajpd_pkg::MAGIC_A1);
    end else begin
      tx_q.push_back(ajpd_pkg::MAGIC_B0);
      tx_q.push_back(ajpd_pkg::MAGIC_B1);
    end
  endfunction

  function automatic void add_packet(logic [15:0] len, logic [7:0] mtype, logic [15:0] clen);
    int rest;
    add_magic();
    tx_q.push_back(len[15:8]);
    tx_q.push_back(len[7:0]);
    tx_q.push_back(mtype);
    rest = int'(len) - 1;
    if (mtype == ajpd_pkg::MSG_SEND_BODY_CHUNK && len >= 16'd3) begin
      tx_q.push_back(clen[15:8]);
      tx_q.push_back(clen[7:0]);
      rest = rest - 2;
    end
    repeat (rest) tx_q.push_back(8'($urandom));
  endfunction

  // mostly body chunks, with end events and silently skipped types mixed in
  function automatic void add_random_packet(int len);
    int          r;
    int          room;
    logic [7:0]  mtype;
    logic [15:0] clen;
    r = $urandom_range(0, 99);
    if (len >= 3 && r < 60) begin
      mtype = ajpd_pkg::MSG_SEND_BODY_CHUNK;
    end else if (r < 78) begin
      mtype = ajpd_pkg::MSG_END_RESPONSE;
    end else begin
      mtype = 8'($urandom);
      while (mtype == ajpd_pkg::MSG_SEND_BODY_CHUNK || mtype == ajpd_pkg::MSG_END_RESPONSE)
        mtype = 8'($urandom);
    end
    clen = 16'h0000;
    if (mtype == ajpd_pkg::MSG_SEND_BODY_CHUNK) begin
      room = len - 3;
      r = $urandom_range(0, 99);
      if (r < 10) clen = 16'h0000;
      else if (r < 40) clen = 16'(room);
      else if (r < 70) clen = 16'($urandom_range(0, room));
      else if (r < 75) clen = 16'hFFFF;
      else clen = 16'($urandom_range(room, 65535));
    end
    add_packet(16'(len), mtype, clen);
  endfunction

  initial begin
    int          m;
    int          cap;
    int          kind;
    int          len;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] len16;
    int          limits[5];
    string       kind_names[4];

    kind_names = '{"bad magic", "zero length", "oversize length", "missing chunk header"};
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed packets at the reset length limit
    // chunk of one byte followed by a trailing byte that is dropped
    tx_q = {tx_q, ajpd_pkg::MAGIC_A0, ajpd_pkg::MAGIC_A1, 8'h00, 8'h05,
            ajpd_pkg::MSG_SEND_BODY_CHUNK, 8'h00, 8'h01, 8'hFF, 8'h77};
    // end of response as the only body byte
    tx_q = {tx_q, ajpd_pkg::MAGIC_B0, ajpd_pkg::MAGIC_B1, 8'h00, 8'h01,
            ajpd_pkg::MSG_END_RESPONSE};
    // chunk length far past the packet end, clipped to the one byte left
    tx_q = {tx_q, ajpd_pkg::MAGIC_B0, ajpd_pkg::MAGIC_B1, 8'h00, 8'h04,
            ajpd_pkg::MSG_SEND_BODY_CHUNK, 8'hFF, 8'hFF, 8'h80};
    // zero-length chunk gives no item at all
    tx_q = {tx_q, ajpd_pkg::MAGIC_A0, ajpd_pkg::MAGIC_A1, 8'h00, 8'h03,
            ajpd_pkg::MSG_SEND_BODY_CHUNK, 8'h00, 8'h00};
    flush_tx();
    wait_idle();

    // random packets under several length limits, the extremes among them
    limits = '{65535, 1, 2, 48, $urandom_range(3, 250)};
    foreach (limits[i]) begin
      m = limits[i];
      write_max(16'(m));
      if (m != 65535) begin
        // a packet right at the limit
        add_random_packet(m);
      end
      if (m == 48) begin
        // receiver holds off while a long chunk streams in, so the input backs up
        flush_tx();
        hold_asked++;
        add_packet(16'd48, ajpd_pkg::MSG_SEND_BODY_CHUNK, 16'd45);
      end
      cap = (m < 40) ? m : 40;
      while (tx_q.size() < 130) begin
        if (m == 65535 && $urandom_range(0, 9) == 0) len = $urandom_range(41, 400);
        else len = $urandom_range(1, cap);
        add_random_packet(len);
      end
      flush_tx();
      wait_idle();
    end

    // close with one format error; everything after it must stay silent
    kind = $urandom_range(0, 3);
    if (kind == 3) m = $urandom_range(2, 65535);
    else if (kind == 2 && $urandom_range(0, 1) == 1) m = $urandom_range(1, 65534);
    else m = 0;
    write_max(16'(m));
    case (kind)
      0: begin
        case ($urandom_range(0, 2))
          0:       b0 = ajpd_pkg::MAGIC_A0;
          1:       b0 = ajpd_pkg::MAGIC_B0;
          default: b0 = 8'($urandom);
        endcase
        b1 = 8'($urandom);
        while ((b0 == ajpd_pkg::MAGIC_A0 && b1 == ajpd_pkg::MAGIC_A1) ||
               (b0 == ajpd_pkg::MAGIC_B0 && b1 == ajpd_pkg::MAGIC_B1))
          b1 = 8'($urandom);
        tx_q = {tx_q, b0, b1};
      end
      1: begin
        add_magic();
        tx_q = {tx_q, 8'h00, 8'h00};
      end
      2: begin
        add_magic();
        len16 = 16'($urandom_range(m + 1, 65535));
        tx_q = {tx_q, len16[15:8], len16[7:0]};
      end
      default: begin
        add_magic();
        len16 = 16'($urandom_range(1, 2));
        tx_q = {tx_q, len16[15:8], len16[7:0], ajpd_pkg::MSG_SEND_BODY_CHUNK};
      end
    endcase
    repeat (24) tx_q.push_back(8'($urandom));
    add_packet(16'd1, ajpd_pkg::MSG_END_RESPONSE, 16'h0000);
    flush_tx();
    wait_idle();

    if (sb.owed_q.size() != 0)
      sb.flag($sformatf("%0d result items never arrived", sb.owed_q.size()));

    $display("covered %0d bytes under %0d length limit writes: %0d payload items, %0d end events",
             sb.n_bytes, n_writes, sb.n_data, sb.n_end);
    $display("closing error case: %s, %0d error items, %0d failures",
             kind_names[kind], sb.n_err, sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("ajp13_body_chunk_deframer_core test passed");
    end else begin
      $display("ajp13_body_chunk_deframer_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("ajp13_body_chunk_deframer_core test failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ajpd_pkg.sv
rtl/ajpd_in_stage.sv
rtl/ajpd_parser.sv
rtl/ajpd_out_reg.sv
rtl/ajp13_body_chunk_deframer_core.sv
verif/tb_ajp13_body_chunk_deframer_core.sv
